>>> hw/rtl/mstt_pkg.sv
// mstt_pkg: shared constants and types for the multi-slot timeout timer
// no dependencies; imported by every module of the block
package mstt_pkg;

    // fixed field widths
    localparam int FUNC_W = 3;
    localparam int SLOT_W = 4;
    localparam int DEST_W = 4;
    localparam int PAY_W  = 8;
    localparam int TIME_W = 32;

    // most expiry events one tick may produce
    localparam int RESULT_CAP = 16;
    localparam int FIRE_W     = 5;

    // command codes
    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ARM   = 3'd4;

    // result kinds
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // sequencer to scan unit
    typedef struct packed {
        logic clear;      // drop the current best candidate
        logic mode_tick;  // 1 tick search, 0 free slot search
        logic valid;      // slot data on the read port is live
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic a_busy;     // compare stage still holds an entry
        logic found;      // a candidate has been picked
    } t_scan_res;

endpackage

>>> hw/rtl/multi_slot_timeout_timer.sv
// multi_slot_timeout_timer: free, set and arm are done straight from idle and give no result.
// allocate and tick searches read one slot a cycle: allocate answers after one full scan
// of all slots; a tick scans all slots once, then scans them all again after each fired
// slot, but a sixteenth fire ends the tick with no further scan.
// results appear as one-cycle o_strobe pulses; the receiver cannot stall them.
// reset clears the tick count, arm sequence and all slot status to free.
module multi_slot_timeout_timer
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [DEST_W-1:0] i_dest_id,
    input  logic [PAY_W-1:0]  i_payload,
    input  logic [TIME_W-1:0] i_delay,
    output logic              o_strobe,
    output logic              o_kind,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [DEST_W-1:0] o_dest_out,
    output logic [PAY_W-1:0]  o_payload_out,
    output logic              o_ok,
    output logic              o_last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FETCH = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [SW-1:0]         r_scan, n_scan;
    logic                  r_v1, n_v1;
    logic [SW-1:0]         r_idx1, n_idx1;
    logic                  r_is_tick, n_is_tick;
    logic [FIRE_W-1:0]     r_fires, n_fires;
    logic                  r_pend_valid, n_pend_valid;
    logic [SW-1:0]         r_pend_slot, n_pend_slot;
    logic [TIME_W-1:0]     r_tick, n_tick;
    logic [TIME_W-1:0]     r_seq, n_seq;
    logic [NUM_SLOTS-1:0]  r_used, n_used;
    logic [NUM_SLOTS-1:0]  r_armed, n_armed;

    logic                  r_o_strobe, n_o_strobe;
    logic                  r_o_kind, n_o_kind;
    logic [SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic [DEST_W-1:0]     r_o_dest, n_o_dest;
    logic [PAY_W-1:0]      r_o_pay, n_o_pay;
    logic                  r_o_ok, n_o_ok;
    logic                  r_o_last, n_o_last;

    logic                  cmd_acc;
    logic                  in_range;
    logic [IW-1:0]         slot_wide;
    logic [SW-1:0]         sidx;
    logic [IW-1:0]         pend_wide;
    logic [IW-1:0]         best_wide;

    logic                  tw_en;
    logic                  dw_en;
    logic                  dr_en;
    logic [TIME_W-1:0]     tr_exp;
    logic [TIME_W-1:0]     tr_stamp;
    logic [DEST_W-1:0]     dr_dest;
    logic [PAY_W-1:0]      dr_pay;

    t_scan_ctl             scan_ctl;
    logic                  scan_clear;
    t_scan_res             scan_res;
    logic [SW-1:0]         best_idx;

    // command transfer and slot index decode
    assign busy      = (r_state != S_IDLE);
    assign cmd_acc   = start && !busy;
    assign in_range  = (32'(i_slot) < 32'(NUM_SLOTS));
    assign slot_wide = IW'(i_slot);
    assign sidx      = slot_wide[SW-1:0];
    assign pend_wide = IW'(r_pend_slot);
    assign best_wide = IW'(best_idx);

    assign scan_ctl.clear     = scan_clear;
    assign scan_ctl.mode_tick = r_is_tick;
    assign scan_ctl.valid     = r_v1;

    mstt_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_tw_en    (tw_en),
        .i_tw_idx   (sidx),
        .i_tw_exp   (r_tick + i_delay),
        .i_tw_stamp (r_seq + 32'd1),
        .i_tr_idx   (r_scan),
        .o_tr_exp   (tr_exp),
        .o_tr_stamp (tr_stamp),
        .i_dw_en    (dw_en),
        .i_dw_idx   (sidx),
        .i_dw_dest  (i_dest_id),
        .i_dw_pay   (i_payload),
        .i_dr_en    (dr_en),
        .i_dr_idx   (best_idx),
        .o_dr_dest  (dr_dest),
        .o_dr_pay   (dr_pay)
    );

    mstt_scan_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_idx1),
        .i_exp      (tr_exp),
        .i_stamp    (tr_stamp),
        .i_armed    (r_armed[r_idx1]),
        .i_used     (r_used[r_idx1]),
        .i_tick     (r_tick),
        .i_seq      (r_seq),
        .o_res      (scan_res),
        .o_best_idx (best_idx)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_v1         = 1'b0;
        n_idx1       = r_idx1;
        n_is_tick    = r_is_tick;
        n_fires      = r_fires;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_tick       = r_tick;
        n_seq        = r_seq;
        n_used       = r_used;
        n_armed      = r_armed;
        n_o_strobe   = 1'b0;
        n_o_kind     = r_o_kind;
        n_o_slot     = r_o_slot;
        n_o_dest     = r_o_dest;
        n_o_pay      = r_o_pay;
        n_o_ok       = r_o_ok;
        n_o_last     = r_o_last;
        tw_en        = 1'b0;
        dw_en        = 1'b0;
        dr_en        = 1'b0;
        scan_clear   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_func)
                        FN_TICK: begin
                            n_tick       = r_tick + 32'd1;
                            n_is_tick    = 1'b1;
                            n_fires      = '0;
                            n_pend_valid = 1'b0;
                            n_scan       = '0;
                            scan_clear   = 1'b1;
                            n_state      = S_SCAN;
                        end
                        FN_ALLOC: begin
                            n_is_tick  = 1'b0;
                            n_scan     = '0;
                            scan_clear = 1'b1;
                            n_state    = S_SCAN;
                        end
                        FN_FREE: begin
                            if (in_range) begin
                                n_used[sidx]  = 1'b0;
                                n_armed[sidx] = 1'b0;
                            end
                        end
                        FN_SET: begin
                            dw_en = in_range;
                        end
                        FN_ARM: begin
                            if (in_range) begin
                                n_seq         = r_seq + 32'd1;
                                tw_en         = 1'b1;
                                n_used[sidx]  = 1'b1;
                                n_armed[sidx] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle
                n_v1   = 1'b1;
                n_idx1 = r_scan;
                if (r_scan == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !scan_res.a_busy) begin
                    if (r_is_tick) begin
                        // the held fire is last only if nothing more is due
                        if (r_pend_valid) begin
                            n_o_strobe = 1'b1;
                            n_o_kind   = KIND_EXPIRY;
                            n_o_slot   = pend_wide[SLOT_W-1:0];
                            n_o_dest   = dr_dest;
                            n_o_pay    = dr_pay;
                            n_o_ok     = 1'b1;
                            n_o_last   = !scan_res.found;
                        end
                        n_pend_valid = 1'b0;
                        n_state      = scan_res.found ? S_FETCH : S_IDLE;
                    end else begin
                        // allocation answer
                        n_o_strobe = 1'b1;
                        n_o_kind   = KIND_ANSWER;
                        n_o_dest   = '0;
                        n_o_pay    = '0;
                        n_o_last   = 1'b1;
                        n_o_ok     = scan_res.found;
                        if (scan_res.found) begin
                            n_o_slot         = best_wide[SLOT_W-1:0];
                            n_used[best_idx] = 1'b1;
                        end else begin
                            n_o_slot = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                // fire the winner: read its data and hold it until we know if it is last
                dr_en             = 1'b1;
                n_armed[best_idx] = 1'b0;
                n_pend_valid      = 1'b1;
                n_pend_slot       = best_idx;
                n_fires           = r_fires + 1'b1;
                if (r_fires == FIRE_W'(RESULT_CAP - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_scan     = '0;
                    scan_clear = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_EMIT: begin
                // fire cap reached
                n_o_strobe   = 1'b1;
                n_o_kind     = KIND_EXPIRY;
                n_o_slot     = pend_wide[SLOT_W-1:0];
                n_o_dest     = dr_dest;
                n_o_pay      = dr_pay;
                n_o_ok       = 1'b1;
                n_o_last     = 1'b1;
                n_pend_valid = 1'b0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_v1         <= 1'b0;
            r_fires      <= '0;
            r_pend_valid <= 1'b0;
            r_tick       <= '0;
            r_seq        <= '0;
            r_used       <= '0;
            r_armed      <= '0;
            r_o_strobe   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_v1         <= n_v1;
            r_fires      <= n_fires;
            r_pend_valid <= n_pend_valid;
            r_tick       <= n_tick;
            r_seq        <= n_seq;
            r_used       <= n_used;
            r_armed      <= n_armed;
            r_o_strobe   <= n_o_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_idx1      <= n_idx1;
        r_is_tick   <= n_is_tick;
        r_pend_slot <= n_pend_slot;
        r_o_kind    <= n_o_kind;
        r_o_slot    <= n_o_slot;
        r_o_dest    <= n_o_dest;
        r_o_pay     <= n_o_pay;
        r_o_ok      <= n_o_ok;
        r_o_last    <= n_o_last;
    end

    assign o_strobe      = r_o_strobe;
    assign o_kind        = r_o_kind;
    assign o_slot_out    = r_o_slot;
    assign o_dest_out    = r_o_dest;
    assign o_payload_out = r_o_pay;
    assign o_ok          = r_o_ok;
    assign o_last        = r_o_last;

endmodule

>>> hw/rtl/mstt_slot_store.sv
// mstt_slot_store: per-slot memories (expiry/arm stamp and destination/data)
// depends on mstt_pkg; one write and one registered read port per memory
module mstt_slot_store
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic              i_clk,
    // expiry and arm stamp memory
    input  logic              i_tw_en,
    input  logic [SW-1:0]     i_tw_idx,
    input  logic [TIME_W-1:0] i_tw_exp,
    input  logic [TIME_W-1:0] i_tw_stamp,
    input  logic [SW-1:0]     i_tr_idx,
    output logic [TIME_W-1:0] o_tr_exp,
    output logic [TIME_W-1:0] o_tr_stamp,
    // destination and data memory
    input  logic              i_dw_en,
    input  logic [SW-1:0]     i_dw_idx,
    input  logic [DEST_W-1:0] i_dw_dest,
    input  logic [PAY_W-1:0]  i_dw_pay,
    input  logic              i_dr_en,
    input  logic [SW-1:0]     i_dr_idx,
    output logic [DEST_W-1:0] o_dr_dest,
    output logic [PAY_W-1:0]  o_dr_pay
);

    logic [2*TIME_W-1:0]     r_time_mem [NUM_SLOTS];
    logic [DEST_W+PAY_W-1:0] r_dp_mem   [NUM_SLOTS];
    logic [2*TIME_W-1:0]     r_time_rd;
    logic [DEST_W+PAY_W-1:0] r_dp_rd;

    // expiry/stamp memory, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_tw_en) begin
            r_time_mem[i_tw_idx] <= {i_tw_exp, i_tw_stamp};
        end
        r_time_rd <= r_time_mem[i_tr_idx];
    end

    // destination/data memory, read on demand so the data holds
    always_ff @(posedge i_clk) begin
        if (i_dw_en) begin
            r_dp_mem[i_dw_idx] <= {i_dw_dest, i_dw_pay};
        end
        if (i_dr_en) begin
            r_dp_rd <= r_dp_mem[i_dr_idx];
        end
    end

    assign o_tr_exp   = r_time_rd[2*TIME_W-1:TIME_W];
    assign o_tr_stamp = r_time_rd[TIME_W-1:0];
    assign o_dr_dest  = r_dp_rd[DEST_W+PAY_W-1:PAY_W];
    assign o_dr_pay   = r_dp_rd[PAY_W-1:0];

endmodule

>>> hw/rtl/mstt_scan_unit.sv
// mstt_scan_unit: two-stage shared compare unit that picks the next slot
// depends on mstt_pkg; fed one slot per cycle by the sequencer
module mstt_scan_unit
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [SW-1:0]     i_idx,
    input  logic [TIME_W-1:0] i_exp,
    input  logic [TIME_W-1:0] i_stamp,
    input  logic              i_armed,
    input  logic              i_used,
    input  logic [TIME_W-1:0] i_tick,
    input  logic [TIME_W-1:0] i_seq,
    output t_scan_res         o_res,
    output logic [SW-1:0]     o_best_idx
);

    logic              r_a_valid;
    logic [SW-1:0]     r_a_idx;
    logic              r_a_cand;
    logic [TIME_W-1:0] r_a_exp;
    logic [TIME_W-1:0] r_a_age;

    logic              r_found;
    logic [SW-1:0]     r_best_idx;
    logic [TIME_W-1:0] r_best_exp;
    logic [TIME_W-1:0] r_best_age;
    logic              take;

    // stage a: due check (tick) or free check (allocate), and age since arming
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_ctl.valid;
        end
        r_a_idx  <= i_idx;
        r_a_cand <= i_ctl.mode_tick ? (i_armed && (i_exp <= i_tick)) : !i_used;
        r_a_exp  <= i_exp;
        r_a_age  <= i_seq - i_stamp;
    end

    // stage b: for ticks, earliest expiry, then most recent arm, then lowest slot; for allocate, lowest free slot
    always_comb begin
        take = r_a_valid && r_a_cand &&
               (!r_found ||
                (i_ctl.mode_tick &&
                 ((r_a_exp < r_best_exp) ||
                  ((r_a_exp == r_best_exp) && (r_a_age < r_best_age)))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
        if (take) begin
            r_best_idx <= r_a_idx;
            r_best_exp <= r_a_exp;
            r_best_age <= r_a_age;
        end
    end

    assign o_res.a_busy = r_a_valid;
    assign o_res.found  = r_found;
    assign o_best_idx   = r_best_idx;

endmodule
